// ===== rtl/core/dwl_pkg.sv =====
// Shared types and constants of the deduplicating worklist.
package dwl_pkg;

  localparam int ID_W         = 10;
  localparam int SIZE_W       = 16;
  localparam int MODE_W       = 2;
  localparam int ORDER_W      = 2;
  localparam int DEF_CAPACITY = 64;
  localparam int DEF_ID_SPACE = 1024;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  typedef enum logic [ORDER_W-1:0] {
    ORD_SMALL = 2'd0,
    ORD_BIG   = 2'd1,
    ORD_OLD   = 2'd2,
    ORD_NEW   = 2'd3
  } order_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   entry_id;
    logic [SIZE_W-1:0] entry_size;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]   head_id;
    logic [SIZE_W-1:0] head_size;
    logic              is_empty;
    logic              was_duplicate;
    logic              overflow;
    logic              underflow;
  } out_t;

  typedef struct packed {
    logic [ORDER_W-1:0] order_mode;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic first;
  } pick_ctl_t;

endpackage

// ===== rtl/core/dwl_ifs.sv =====
// Valid/ready channel interfaces for the worklist's item, result and config beats.
interface dwl_in_if;
  import dwl_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dwl_out_if;
  import dwl_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dwl_cfg_if;
  import dwl_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/dwl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module dwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/dwl_idmod.sv =====
// Reciprocal unit: reduces an entry id modulo the id space by a multiply with a constant.
module dwl_idmod #(
  parameter int ID_SPACE = dwl_pkg::DEF_ID_SPACE
) (
  input  logic                        clk,
  input  logic                        start,
  input  logic [dwl_pkg::ID_W-1:0]    id_in,
  output logic [$clog2(ID_SPACE)-1:0] member
);
  import dwl_pkg::*;

  localparam int MW = $clog2(ID_SPACE);
  localparam int SH = ID_W + MW;
  localparam int RW = ID_W + 2;
  localparam int PW = ID_W + RW;
  // ceil(2^SH / ID_SPACE) gives the exact quotient for every ID_W-bit id
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(ID_SPACE) - 64'd1) / 64'(ID_SPACE);

  logic [ID_W-1:0] id_r;
  logic [ID_W-1:0] quo_r;
  logic [ID_W-1:0] quo_nxt;
  logic [PW-1:0]   prod;
  logic [ID_W-1:0] quo_back;

  // stage one at start: quotient by the reciprocal
  assign prod    = PW'(id_in) * PW'(RECIP);
  assign quo_nxt = ID_W'(prod >> SH);

  always_ff @(posedge clk) begin
    if (start) begin
      id_r  <= id_in;
      quo_r <= quo_nxt;
    end
  end

  // stage two: remainder from the held quotient
  assign quo_back = ID_W'(int'(quo_r) * ID_SPACE);
  assign member   = MW'(id_r - quo_back);

endmodule

// ===== rtl/core/dwl_pick.sv =====
// Shared compare unit: keeps the best entry seen in a scan under the service order.
module dwl_pick #(
  parameter int IDX_W   = 6,
  parameter int ENTRY_W = 36
) (
  input  logic                       clk,
  input  dwl_pkg::order_t            order,
  input  dwl_pkg::pick_ctl_t         ctl,
  input  logic [IDX_W-1:0]           idx,
  input  logic [ENTRY_W-1:0]         entry,
  output logic [IDX_W-1:0]           best_idx,
  output logic [ENTRY_W-1:0]         best_entry
);
  import dwl_pkg::*;

  logic [IDX_W-1:0]   best_idx_r;
  logic [ENTRY_W-1:0] best_entry_r;
  logic [SIZE_W-1:0]  cur_size;
  logic [SIZE_W-1:0]  best_size;
  logic               better;

  assign cur_size  = entry[SIZE_W-1:0];
  assign best_size = best_entry_r[SIZE_W-1:0];

  // strict compares keep the oldest of equal sizes
  always_comb begin
    case (order)
      ORD_SMALL: better = cur_size < best_size;
      ORD_BIG:   better = cur_size > best_size;
      ORD_OLD:   better = 1'b0;
      ORD_NEW:   better = 1'b1;
      default:   better = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && (ctl.first || better)) begin
      best_idx_r   <= idx;
      best_entry_r <= entry;
    end
  end

  assign best_idx   = best_idx_r;
  assign best_entry = best_entry_r;

endmodule

// ===== rtl/core/dedup_worklist_four_orders.sv =====
// Deduplicating worklist with four service orders (smallest size, biggest size, oldest,
// newest first; equal sizes are served oldest first). Each input beat pushes an entry,
// pops the head, or only queries; mode three acts as a query. Every beat yields exactly
// one result beat with the head after the operation (zero when empty), the empty flag
// and the duplicate, overflow and underflow flags. Entries sit in arrival order in a
// CAPACITY-deep slot RAM; membership is one bit per id (id modulo ID_SPACE) in a second
// RAM. After reset the block sweeps that membership RAM clear, and no input beat is
// taken during the sweep (config writes are taken at any time). Items are processed
// one at a time and the block is not ready while one is in flight. A query scans the
// held slots for the head. A push reduces the id by a reciprocal multiply at accept,
// then reads membership, stores the entry unless it is a duplicate or dropped, and
// scans. A pop scans for the head, compacts the slots above it and rescans; on an
// empty worklist it only raises underflow. A result is held while the output register
// stays full. The work is bounded by the slot RAM's single read port, which streams one
// entry a cycle into the shared compare unit or into the compaction write-back. A
// finished result waits in the output register while the next item is accepted.
module dedup_worklist_four_orders #(
  parameter int CAPACITY = dwl_pkg::DEF_CAPACITY,
  parameter int ID_SPACE = dwl_pkg::DEF_ID_SPACE
) (
  input  logic        clk,
  input  logic        rst_n,
  dwl_in_if.sink      in_ch,
  dwl_out_if.source   out_ch,
  dwl_cfg_if.sink     cfg_ch
);
  import dwl_pkg::*;

  localparam int CW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int MW = $clog2(ID_SPACE);
  localparam int EW = MW + ID_W + SIZE_W;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_MCHK,
    ST_SCAN,
    ST_SCAN_END,
    ST_POPC,
    ST_SHIFT,
    ST_SHIFT_END,
    ST_DONE
  } state_t;

  state_t        state_r, state_nxt;
  order_t        order_r, order_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] k_r, k_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pend_idx_r, pend_idx_nxt;
  logic          pop_find_r, pop_find_nxt;
  in_t           item_r, item_nxt;
  logic          dup_r, dup_nxt;
  logic          ovf_r, ovf_nxt;
  logic          unf_r, unf_nxt;
  logic [MW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  // slot RAM ports
  logic          slot_we, slot_re;
  logic [CW-1:0] slot_waddr, slot_raddr;
  logic [EW-1:0] slot_wdata, slot_rdata;
  // membership RAM ports
  logic          mem_we, mem_re;
  logic [MW-1:0] mem_waddr;
  logic [0:0]    mem_wdata, mem_rdata;

  // id reduction and compare unit
  logic          mod_start;
  logic [MW-1:0] member;
  pick_ctl_t     pick_ctl;
  logic [CW-1:0] best_idx;
  logic [EW-1:0] best_entry;

  logic          in_fire, cfg_fire, out_free;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // scan reads feed the compare unit; the first beat of a scan is slot zero
  assign pick_ctl.valid = pend_r && (state_r == ST_SCAN || state_r == ST_SCAN_END);
  assign pick_ctl.first = (pend_idx_r == '0);

  dwl_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  dwl_ram #(
    .WIDTH (1),
    .DEPTH (ID_SPACE)
  ) u_member_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (member),
    .rdata (mem_rdata)
  );

  // the id is taken straight off the accepted beat
  dwl_idmod #(
    .ID_SPACE (ID_SPACE)
  ) u_idmod (
    .clk    (clk),
    .start  (mod_start),
    .id_in  (in_ch.data.entry_id),
    .member (member)
  );

  dwl_pick #(
    .IDX_W   (CW),
    .ENTRY_W (EW)
  ) u_pick (
    .clk        (clk),
    .order      (order_r),
    .ctl        (pick_ctl),
    .idx        (pend_idx_r),
    .entry      (slot_rdata),
    .best_idx   (best_idx),
    .best_entry (best_entry)
  );

  always_comb begin
    state_nxt     = state_r;
    order_nxt     = order_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = k_r[CW-1:0];
    pop_find_nxt  = pop_find_r;
    item_nxt      = item_r;
    dup_nxt       = dup_r;
    ovf_nxt       = ovf_r;
    unf_nxt       = unf_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    slot_re    = 1'b0;
    slot_raddr = k_r[CW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = clr_r;
    mem_wdata  = 1'b0;
    mem_re     = 1'b0;
    mod_start  = 1'b0;

    if (cfg_fire) begin
      order_nxt = order_t'(cfg_ch.data.order_mode);
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // compaction write-back: slot read at k lands one slot lower
    if (pend_r && (state_r == ST_SHIFT || state_r == ST_SHIFT_END)) begin
      slot_we    = 1'b1;
      slot_waddr = pend_idx_r - CW'(1);
      slot_wdata = slot_rdata;
    end

    case (state_r)
      ST_CLEAR: begin
        // sweep the membership RAM to all zero
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = 1'b0;
        clr_nxt   = clr_r + MW'(1);
        if (clr_r == MW'(ID_SPACE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          item_nxt     = in_ch.data;
          dup_nxt      = 1'b0;
          ovf_nxt      = 1'b0;
          unf_nxt      = 1'b0;
          k_nxt        = '0;
          pop_find_nxt = 1'b0;
          case (in_ch.data.mode)
            MODE_PUSH: begin
              mod_start = 1'b1;
              state_nxt = ST_MOD;
            end
            MODE_POP: begin
              if (fill_r == '0) begin
                unf_nxt   = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                pop_find_nxt = 1'b1;
                state_nxt    = ST_SCAN;
              end
            end
            MODE_QUERY: state_nxt = ST_SCAN;
            default:    state_nxt = ST_SCAN;
          endcase
        end
      end
      ST_MOD: begin
        // reduced id is ready; look up membership
        mem_re    = 1'b1;
        state_nxt = ST_MCHK;
      end
      ST_MCHK: begin
        if (mem_rdata[0]) begin
          dup_nxt = 1'b1;
        end else if (fill_r == FW'(CAPACITY)) begin
          ovf_nxt = 1'b1;
        end else begin
          slot_we    = 1'b1;
          slot_waddr = fill_r[CW-1:0];
          slot_wdata = {member, item_r.entry_id, item_r.entry_size};
          mem_we     = 1'b1;
          mem_waddr  = member;
          mem_wdata  = 1'b1;
          fill_nxt   = fill_r + FW'(1);
        end
        k_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // stream held slots into the compare unit
        if (fill_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          slot_re      = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = k_r[CW-1:0];
          if (k_r == fill_r - FW'(1)) begin
            state_nxt = ST_SCAN_END;
          end else begin
            k_nxt = k_r + FW'(1);
          end
        end
      end
      ST_SCAN_END: begin
        state_nxt = pop_find_r ? ST_POPC : ST_DONE;
      end
      ST_POPC: begin
        // drop the head's membership, then close the gap above it
        mem_we    = 1'b1;
        mem_waddr = best_entry[EW-1 -: MW];
        mem_wdata = 1'b0;
        k_nxt     = FW'(best_idx) + FW'(1);
        if (FW'(best_idx) + FW'(1) == fill_r) begin
          state_nxt = ST_SHIFT_END;
        end else begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        slot_re      = 1'b1;
        pend_nxt     = 1'b1;
        pend_idx_nxt = k_r[CW-1:0];
        if (k_r == fill_r - FW'(1)) begin
          state_nxt = ST_SHIFT_END;
        end else begin
          k_nxt = k_r + FW'(1);
        end
      end
      ST_SHIFT_END: begin
        // last moved slot lands this cycle; rescan for the new head
        fill_nxt     = fill_r - FW'(1);
        k_nxt        = '0;
        pop_find_nxt = 1'b0;
        state_nxt    = ST_SCAN;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.was_duplicate = dup_r;
          out_nxt.overflow      = ovf_r;
          out_nxt.underflow     = unf_r;
          if (fill_r == '0) begin
            out_nxt.head_id   = '0;
            out_nxt.head_size = '0;
            out_nxt.is_empty  = 1'b1;
          end else begin
            out_nxt.head_id   = best_entry[SIZE_W +: ID_W];
            out_nxt.head_size = best_entry[SIZE_W-1:0];
            out_nxt.is_empty  = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      order_r     <= ORD_SMALL;
      fill_r      <= '0;
      k_r         <= '0;
      pend_r      <= 1'b0;
      pop_find_r  <= 1'b0;
      dup_r       <= 1'b0;
      ovf_r       <= 1'b0;
      unf_r       <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      order_r     <= order_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      pend_r      <= pend_nxt;
      pop_find_r  <= pop_find_nxt;
      dup_r       <= dup_nxt;
      ovf_r       <= ovf_nxt;
      unf_r       <= unf_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_idx_r <= pend_idx_nxt;
    item_r     <= item_nxt;
    out_r      <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_r.was_duplicate, out_r.overflow, out_r.underflow}))
    else $error("more than one result flag set");

  a_empty_zero_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.is_empty) |-> (out_r.head_id == '0 && out_r.head_size == '0))
    else $error("empty result with nonzero head");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("ready again right after accepting a beat");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_r)
    else $error("slot read in flight while idle");
`endif

endmodule
